// ===== hw/rtl/button_packet_parser_volume_assert.svh =====
// assertion macros for the button packet parser checker
// depends on: nothing; expects i_clk and i_rst_n in the including scope
`ifndef BUTTON_PACKET_PARSER_VOLUME_ASSERT_SVH
`define BUTTON_PACKET_PARSER_VOLUME_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define BPP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bpp assertion failed");

// next-cycle implication, disabled while reset is low
`define BPP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bpp assertion failed");

`endif

// ===== hw/rtl/bpp_pkg.sv =====
// shared types, constants and helpers for the button packet parser
// depends on: nothing
package bpp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CMD_W  = 3;
    localparam int unsigned VOL_W  = 5;
    localparam int unsigned LED_W  = 4;

    // frame framing bytes
    localparam logic [BYTE_W-1:0] HDR_BYTE  = 8'h21;
    localparam logic [BYTE_W-1:0] TYPE_BYTE = 8'h42;

    // button codes
    localparam logic [BYTE_W-1:0] BTN_PLAY  = 8'h31;
    localparam logic [BYTE_W-1:0] BTN_STOP  = 8'h32;
    localparam logic [BYTE_W-1:0] BTN_SAVE  = 8'h33;
    localparam logic [BYTE_W-1:0] BTN_LOAD  = 8'h34;
    localparam logic [BYTE_W-1:0] BTN_VUP   = 8'h35;
    localparam logic [BYTE_W-1:0] BTN_VDOWN = 8'h36;

    // command codes reported on the result
    localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PLAY  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SAVE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_VUP   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_VDOWN = 3'd6;

    // volume steps of 0.05
    localparam logic [VOL_W-1:0] VOL_MAX   = 5'd20;
    localparam logic [VOL_W-1:0] VOL_RESET = 5'd10;
    localparam logic [VOL_W-1:0] VOL_Q3    = 5'd15;
    localparam logic [VOL_W-1:0] VOL_Q1    = 5'd5;

    // bar patterns
    localparam logic [LED_W-1:0] LED_FULL = 4'hF;
    localparam logic [LED_W-1:0] LED_Q3   = 4'h7;
    localparam logic [LED_W-1:0] LED_HALF = 4'h3;
    localparam logic [LED_W-1:0] LED_Q1   = 4'h1;
    localparam logic [LED_W-1:0] LED_OFF  = 4'h0;

    // one result of a parsed byte
    typedef struct packed {
        logic             frame_ok;
        logic [CMD_W-1:0] command;
        logic             playing;
        logic [VOL_W-1:0] volume_level;
        logic [LED_W-1:0] level_leds;
    } t_result;

    // four-led volume bar
    function automatic logic [LED_W-1:0] bar_of(input logic [VOL_W-1:0] v);
        logic [LED_W-1:0] leds;
        if (v >= VOL_MAX) begin
            leds = LED_FULL;
        end else if (v >= VOL_Q3) begin
            leds = LED_Q3;
        end else if (v >= VOL_RESET) begin
            leds = LED_HALF;
        end else if (v >= VOL_Q1) begin
            leds = LED_Q1;
        end else begin
            leds = LED_OFF;
        end
        return leds;
    endfunction

endpackage

// ===== hw/rtl/bpp_parser.sv =====
// frame parser state machine, checksum check and volume/play state
// depends on: bpp_pkg
module bpp_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [bpp_pkg::BYTE_W-1:0]    i_byte,
    output bpp_pkg::t_result              o_result
);
    import bpp_pkg::*;

    typedef enum logic [4:0] {
        PH_HUNT   = 5'b00001,
        PH_TYPE   = 5'b00010,
        PH_BUTTON = 5'b00100,
        PH_HIT    = 5'b01000,
        PH_CHECK  = 5'b10000
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_button, n_button;
    logic [BYTE_W-1:0] r_hit, n_hit;
    logic [VOL_W-1:0]  r_volume, n_volume;
    logic              r_play, n_play;
    logic              frame_ok;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] want;

    // expected checksum: inverse of the byte sum of the frame so far
    assign want = ~(HDR_BYTE + TYPE_BYTE + r_button + r_hit);

    // next state and result for the byte in the input register
    always_comb begin
        n_phase  = r_phase;
        n_button = r_button;
        n_hit    = r_hit;
        n_volume = r_volume;
        n_play   = r_play;
        frame_ok = 1'b0;
        command  = CMD_NONE;
        case (r_phase)
            PH_TYPE: begin
                n_phase = (i_byte == TYPE_BYTE) ? PH_BUTTON : PH_HUNT;
            end
            PH_BUTTON: begin
                n_button = i_byte;
                n_phase  = PH_HIT;
            end
            PH_HIT: begin
                n_hit   = i_byte;
                n_phase = PH_CHECK;
            end
            PH_CHECK: begin
                n_phase = PH_HUNT;
                if (i_byte == want) begin
                    frame_ok = 1'b1;
                    case (r_button)
                        BTN_PLAY: begin
                            command = CMD_PLAY;
                            n_play  = 1'b1;
                        end
                        BTN_STOP: begin
                            command = CMD_STOP;
                            n_play  = 1'b0;
                        end
                        BTN_SAVE:  command = CMD_SAVE;
                        BTN_LOAD:  command = CMD_LOAD;
                        BTN_VUP: begin
                            command = CMD_VUP;
                            if (r_volume < VOL_MAX) begin
                                n_volume = r_volume + 1'b1;
                            end
                        end
                        BTN_VDOWN: begin
                            command = CMD_VDOWN;
                            if (r_volume != '0) begin
                                n_volume = r_volume - 1'b1;
                            end
                        end
                        default: command = CMD_NONE;
                    endcase
                end
            end
            default: begin
                n_phase = (i_byte == HDR_BYTE) ? PH_TYPE : PH_HUNT;
            end
        endcase
    end

    // result reflects the state after this byte
    assign o_result.frame_ok     = frame_ok;
    assign o_result.command      = command;
    assign o_result.playing      = n_play;
    assign o_result.volume_level = n_volume;
    assign o_result.level_leds   = bar_of(n_volume);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_volume <= VOL_RESET;
            r_play   <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_volume <= n_volume;
            r_play   <= n_play;
        end
    end

    // frame bytes, always written before they are used
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_button <= n_button;
            r_hit    <= n_hit;
        end
    end

endmodule

// ===== hw/rtl/button_packet_parser_volume.sv =====
// top level of the serial button packet parser with volume control
// depends on: bpp_pkg, bpp_parser
//
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+------------------------------------------
// rx byte   | in        | i_valid / o_ready  | i_rx_byte
// result    | out       | o_valid / i_ready  | o_frame_ok o_command o_playing
//           |           |                    | o_volume_level o_level_leds
//
// one byte per cycle sustained while i_ready holds; the result is valid once the accepted request has passed
// the input register, then the parser logic into the result register
// synchronous active-low reset: parser hunts for the header, volume 10, paused
// when the result is stalled the input register still takes one more request,
// then o_ready drops until the result register is taken
module button_packet_parser_volume (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [bpp_pkg::BYTE_W-1:0]  i_rx_byte,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_frame_ok,
    output logic [bpp_pkg::CMD_W-1:0]   o_command,
    output logic                        o_playing,
    output logic [bpp_pkg::VOL_W-1:0]   o_volume_level,
    output logic [bpp_pkg::LED_W-1:0]   o_level_leds
);
    import bpp_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    t_result           result;
    logic              load_out;
    logic              step;

    // result register may load when empty or being drained
    assign load_out = !r_out_valid || i_ready;
    assign step     = r_in_valid && load_out;
    assign o_ready  = !r_in_valid || load_out;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // parser core
    bpp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_result (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_frame_ok     = r_out.frame_ok;
    assign o_command      = r_out.command;
    assign o_playing      = r_out.playing;
    assign o_volume_level = r_out.volume_level;
    assign o_level_leds   = r_out.level_leds;

endmodule

// ===== hw/rtl/bpp_checker.sv =====
// port-level checks for the button packet parser, bound to the top level
// depends on: bpp_pkg, button_packet_parser_volume_assert.svh
`include "button_packet_parser_volume_assert.svh"

module bpp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic [bpp_pkg::BYTE_W-1:0]  i_rx_byte,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic                        o_frame_ok,
    input logic [bpp_pkg::CMD_W-1:0]   o_command,
    input logic                        o_playing,
    input logic [bpp_pkg::VOL_W-1:0]   o_volume_level,
    input logic [bpp_pkg::LED_W-1:0]   o_level_leds
);
    import bpp_pkg::*;

    logic [BYTE_W-1:0] unused_byte;
    logic              unused_flow;
    assign unused_byte = i_rx_byte;
    assign unused_flow = i_valid & o_ready;

    // stalled result holds
    `BPP_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_command) && $stable(o_frame_ok) && $stable(o_volume_level) && $stable(o_playing))

    // a command only comes with a good frame
    `BPP_ASSERT_NOW(a_cmd_needs_frame, o_valid && (o_command != CMD_NONE), o_frame_ok)

    // volume stays in range and the bar follows it
    `BPP_ASSERT_NOW(a_bar_matches, o_valid, (o_volume_level <= VOL_MAX) && (o_level_leds == bar_of(o_volume_level)))

    // play and stop set the playback flag
    `BPP_ASSERT_NOW(a_play_flag, o_valid && ((o_command == CMD_PLAY) || (o_command == CMD_STOP)), o_playing == (o_command == CMD_PLAY))

endmodule

bind button_packet_parser_volume bpp_checker u_bpp_checker (.*);
